@@ rtl/core/ifhg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifhg_pkg
// Shared types and constants for the IPv4 fragment header generator.
// ----------------------------------------------------------------------------
package ifhg_pkg;

    // Header size in bytes (IHL * 4), option words are zero
    localparam int HEADER_BYTES = 24;
    // Hard limit on results produced for one segment
    localparam int RESULT_LIMIT = 62;

    localparam logic [10:0] MTU_RESET  = 11'd1500;
    localparam logic [7:0]  VER_IHL    = 8'h40 | 8'(HEADER_BYTES / 4);
    localparam logic [7:0]  TTL_VALUE  = 8'd64;
    localparam logic [15:0] FLAG_DF    = 16'h4000;
    localparam logic [15:0] FLAG_MF    = 16'h2000;

    // Configuration register indexes
    localparam logic [1:0] CFG_MTU  = 2'd0;
    localparam logic [1:0] CFG_SRC  = 2'd1;
    localparam logic [1:0] CFG_DST  = 2'd2;
    localparam logic [1:0] CFG_DF   = 2'd3;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [7:0]  upper_protocol;
        logic [15:0] identification;
    } t_in_item;

    typedef struct packed {
        logic [15:0] total_length;
        logic [15:0] flags_offset;
        logic [15:0] header_checksum;
        logic [15:0] ident_out;
        logic [7:0]  protocol_out;
        logic        is_error;
        logic        last_fragment;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;   // latch input beat
        logic prep;   // length checks, address sum
        logic base;   // fold checksum base, fragment-count check
        logic emit;   // load one result into the output register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;      // the result emitted now ends the segment
        logic out_free;  // output register can take a result this cycle
    } t_ctrl_stat;

endpackage

@@ rtl/core/ifhg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifhg_ctrl
// Sequencer: accept a segment, run two setup steps, then emit results.
// ----------------------------------------------------------------------------
module ifhg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ifhg_pkg::t_ctrl_stat  i_stat,
    output ifhg_pkg::t_ctrl_cmd   o_cmd
);
    import ifhg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_BASE,
        ST_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   w_accept;

    assign w_accept   = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.load = w_accept;
        o_cmd.prep = (r_state == ST_PREP);
        o_cmd.base = (r_state == ST_BASE);
        o_cmd.emit = (r_state == ST_EMIT) && i_stat.out_free;
    end

    // State and ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_in_ready <= !w_accept;
                    if (w_accept) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_state <= ST_BASE;
                end
                ST_BASE: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (i_stat.out_free && i_stat.last) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/ifhg_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifhg_dpath
// Config registers, segment registers, fragment walk and checksum, plus the
// output register.
// ----------------------------------------------------------------------------
module ifhg_dpath #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_wr_data,
    input  ifhg_pkg::t_in_item    i_in_data,
    input  ifhg_pkg::t_ctrl_cmd   i_cmd,
    output ifhg_pkg::t_ctrl_stat  o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ifhg_pkg::t_out_item   o_out_data
);
    import ifhg_pkg::*;

    localparam int CAP   = (MAX_FRAGMENTS < RESULT_LIMIT) ? MAX_FRAGMENTS : RESULT_LIMIT;
    localparam int PRODW = 11 + $clog2(CAP + 1);

    // Config
    logic [10:0] r_mtu;
    logic [31:0] r_src;
    logic [31:0] r_dst;
    logic        r_df;

    // Segment
    logic [15:0] r_len;
    logic [15:0] r_rem;
    logic [12:0] r_off;
    logic [7:0]  r_proto;
    logic [15:0] r_ident;
    logic        r_fits;
    logic [10:0] r_unit;
    logic [17:0] r_addr_sum;
    logic [15:0] r_base;
    logic        r_too_many;

    // Output
    logic        r_out_valid;
    t_out_item   r_out;

    // Setup-step logic
    logic [11:0]      w_avail;
    logic             w_fits;
    logic [10:0]      w_unit;
    logic [18:0]      w_base_sum;
    logic [16:0]      w_base_f1;
    logic [PRODW-1:0] w_cap_bytes;

    // Emit logic
    logic        w_err;
    logic        w_frag_last;
    logic        w_last;
    logic [15:0] w_tot;
    logic [15:0] w_flg;
    logic [17:0] w_ck_sum;
    logic [16:0] w_ck_f1;
    logic [15:0] w_ck_f2;
    t_out_item   n_out;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu <= MTU_RESET;
            r_src <= '0;
            r_dst <= '0;
            r_df  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MTU: r_mtu <= i_cfg_wr_data[10:0];
                CFG_SRC: r_src <= i_cfg_wr_data;
                CFG_DST: r_dst <= i_cfg_wr_data;
                CFG_DF:  r_df  <= i_cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Room for payload after the header; top bit set means negative
    assign w_avail = {1'b0, r_mtu} - 12'(HEADER_BYTES);
    assign w_fits  = !w_avail[11] && (r_len <= {5'b0, w_avail[10:0]});
    assign w_unit  = (!w_avail[11] && (w_avail[10:3] != '0)) ? {w_avail[10:3], 3'b000}
                                                             : '0;

    // Checksum base: all words that do not change across fragments
    assign w_base_sum = 19'(r_addr_sum) + 19'({VER_IHL, 8'h00}) + 19'(r_ident)
                      + 19'({TTL_VALUE, r_proto});
    assign w_base_f1  = 17'(w_base_sum[15:0]) + 17'(w_base_sum[18:16]);

    // Largest payload that still fits in CAP fragments
    assign w_cap_bytes = PRODW'(r_unit) * PRODW'(CAP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len   <= i_in_data.payload_length;
            r_rem   <= i_in_data.payload_length;
            r_proto <= i_in_data.upper_protocol;
            r_ident <= i_in_data.identification;
            r_off   <= '0;
        end
        if (i_cmd.prep) begin
            r_fits     <= w_fits;
            r_unit     <= w_unit;
            r_addr_sum <= 18'(r_src[31:16]) + 18'(r_src[15:0])
                        + 18'(r_dst[31:16]) + 18'(r_dst[15:0]);
        end
        if (i_cmd.base) begin
            r_base     <= w_base_f1[15:0] + 16'(w_base_f1[16]);
            r_too_many <= 32'(r_len) > 32'(w_cap_bytes);
        end
        // Step to the next fragment
        if (i_cmd.emit && !r_fits && !w_err && !w_frag_last) begin
            r_rem <= r_rem - {5'b0, r_unit};
            r_off <= r_off + 13'(r_unit[10:3]);
        end
    end

    // Fragment fields
    assign w_err       = !r_fits && (r_df || (r_unit == '0) || r_too_many);
    assign w_frag_last = (r_rem <= {5'b0, r_unit});
    assign w_last      = r_fits || w_err || w_frag_last;

    always_comb begin
        if (r_fits) begin
            w_tot = r_len + 16'(HEADER_BYTES);
            w_flg = FLAG_DF;
        end else if (w_frag_last) begin
            w_tot = r_rem + 16'(HEADER_BYTES);
            w_flg = {3'b000, r_off};
        end else begin
            w_tot = {5'b0, r_unit} + 16'(HEADER_BYTES);
            w_flg = FLAG_MF | {3'b000, r_off};
        end
    end

    // Ones-complement sum with end-around carry
    assign w_ck_sum = 18'(r_base) + 18'(w_tot) + 18'(w_flg);
    assign w_ck_f1  = 17'(w_ck_sum[15:0]) + 17'(w_ck_sum[17:16]);
    assign w_ck_f2  = w_ck_f1[15:0] + 16'(w_ck_f1[16]);

    always_comb begin
        n_out.ident_out     = r_ident;
        n_out.protocol_out  = r_proto;
        n_out.is_error      = w_err;
        n_out.last_fragment = w_last;
        if (w_err) begin
            n_out.total_length    = '0;
            n_out.flags_offset    = '0;
            n_out.header_checksum = '0;
        end else begin
            n_out.total_length    = w_tot;
            n_out.flags_offset    = w_flg;
            n_out.header_checksum = ~w_ck_f2;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;
    assign o_stat.last     = w_last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

@@ rtl/core/ipv4_fragment_header_gen_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_fragment_header_gen_unit
// IPv4 header generator: one header per fragment of an upper-layer segment.
// ----------------------------------------------------------------------------
// Setup: after the input beat is accepted, the PREP and BASE steps run.
// Results: then one result per cycle (1 to 62 per segment) from the fragment
//   walk, while the output register is free (no back-pressure stalls it).
// Next input beat is accepted the cycle after the last result is loaded.
// Reset: synchronous active low; config to defaults (MTU 1500), output empty.
module ipv4_fragment_header_gen_unit #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ifhg_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ifhg_pkg::t_out_item  o_out_data
);
    import ifhg_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_ctrl_stat w_stat;

    // Sequencer
    ifhg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath
    ifhg_dpath #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule

@@ rtl/core/ifhg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifhg_checker
// Port-level checks for the IPv4 fragment header generator.
// ----------------------------------------------------------------------------
module ifhg_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  ifhg_pkg::t_out_item  o_out_data
);
    import ifhg_pkg::*;

    // Output register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    // One segment at a time: no second input beat right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

    // Error result is a single closing beat with cleared header fields
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_error |->
            o_out_data.last_fragment && (o_out_data.total_length == '0)
            && (o_out_data.header_checksum == '0))
        else $error("malformed error result");

endmodule

bind ipv4_fragment_header_gen_unit ifhg_checker u_ifhg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
